>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define PCC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define PCC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

  typedef struct packed {
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] prev_z;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
  } pcc_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               hit;
  } pcc_out_t;

  typedef enum logic [2:0] {
    REG_PLANE_POINT_X = 3'd0,
    REG_PLANE_POINT_Y = 3'd1,
    REG_PLANE_POINT_Z = 3'd2,
    REG_UNIT_NORMAL_X = 3'd3,
    REG_UNIT_NORMAL_Y = 3'd4,
    REG_UNIT_NORMAL_Z = 3'd5,
    REG_FRICTION      = 3'd6
  } pcc_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // 1.0 in Q1.16 and the lift distance 0.0001 in Q.32.
  localparam logic [16:0]        ONE_Q16  = 17'd65536;
  localparam logic signed [39:0] LIFT_Q32 = 40'sd429497;

  localparam logic signed [17:0] NORMAL_Y_RESET = 18'sd65536;

endpackage

`default_nettype wire

>>> hw/rtl/plane_collision_correct_top.sv
`default_nettype none

// Point-versus-plane collision response with friction. Each transfer on the input
// channel carries a particle's previous and current position in Q16.16, and each
// produces exactly one result transfer: the current position unchanged when the
// step did not cross the plane, or else the position projected onto the plane,
// lifted by 0.0001 along the normal and pulled back toward the previous position
// by the friction fraction, saturated to 32 bits, with hit set. The datapath is a
// seven-stage register pipeline that takes a new item in every cycle while in_ready
// is high; out_valid is the valid bit of the last stage. Each stage holds its item
// only while the stage after it is full and stalled, so empty stages close up
// behind a stalled output. The normal must be written as a unit vector in Q1.16;
// configuration writes are always taken (cfg_ready stays high), indexes past the
// friction register are ignored, and writes must happen while no item is in flight.
module plane_collision_correct_top
  import pcc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire pcc_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output pcc_out_t                    out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NSTG = 7;

  // Configuration registers.
  logic signed [31:0] point_r  [3];
  logic signed [17:0] normal_r [3];
  logic        [16:0] fric_r;

  // Values derived from configuration alone.
  logic signed [7:0]  lift_r [3];
  logic signed [7:0]  lift_nxt [3];
  logic signed [39:0] lift_prod [3];
  logic        [16:0] fric_clamp;
  logic        [16:0] scale_r;
  logic        [16:0] scale_nxt;

  // Pipeline control.
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  // Input unpacking.
  logic signed [31:0] in_prev [3];
  logic signed [31:0] in_cur  [3];

  // Stage 0: differences to the plane point.
  logic signed [31:0] s0_prev_r [3];
  logic signed [31:0] s0_cur_r  [3];
  logic signed [32:0] s0_dl_r   [3];
  logic signed [32:0] s0_dp_r   [3];
  logic signed [32:0] s0_dl_nxt [3];
  logic signed [32:0] s0_dp_nxt [3];

  // Stage 1: products with the normal.
  logic signed [31:0] s1_prev_r [3];
  logic signed [31:0] s1_cur_r  [3];
  logic signed [50:0] s1_pl_r   [3];
  logic signed [50:0] s1_pp_r   [3];
  logic signed [50:0] s1_pl_nxt [3];
  logic signed [50:0] s1_pp_nxt [3];

  // Stage 2: dot products.
  logic signed [31:0] s2_prev_r [3];
  logic signed [31:0] s2_cur_r  [3];
  logic signed [52:0] s2_dl_r;
  logic signed [52:0] s2_dp_r;
  logic signed [52:0] s2_dl_nxt;
  logic signed [52:0] s2_dp_nxt;

  // Stage 3: crossing test and distance times normal.
  logic signed [31:0] s3_prev_r [3];
  logic signed [31:0] s3_cur_r  [3];
  logic               s3_hit_r;
  logic signed [55:0] s3_ap_r   [3];
  logic               s3_hit_nxt;
  logic signed [55:0] s3_ap_nxt [3];
  logic signed [53:0] dist_sum;
  logic signed [37:0] plane_dist;

  // Stage 4: correction vector.
  logic signed [31:0] s4_prev_r [3];
  logic signed [31:0] s4_cur_r  [3];
  logic               s4_hit_r;
  logic signed [41:0] s4_corr_r [3];
  logic signed [41:0] s4_corr_nxt [3];
  logic signed [56:0] along_sum [3];

  // Stage 5: correction scaled by one minus friction.
  logic signed [31:0] s5_prev_r [3];
  logic signed [31:0] s5_cur_r  [3];
  logic               s5_hit_r;
  logic signed [59:0] s5_m_r    [3];
  logic signed [59:0] s5_m_nxt  [3];

  // Stage 6: output register.
  pcc_out_t           s6_out_r;
  pcc_out_t           s6_out_nxt;
  logic signed [60:0] moved_sum [3];
  logic signed [45:0] pos_sum   [3];
  logic signed [31:0] pos_sat   [3];

  // Configuration write port.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r[0]  <= '0;
      point_r[1]  <= '0;
      point_r[2]  <= '0;
      normal_r[0] <= '0;
      normal_r[1] <= NORMAL_Y_RESET;
      normal_r[2] <= '0;
      fric_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcc_reg_t'(cfg_index))
        REG_PLANE_POINT_X: point_r[0]  <= signed'(cfg_data);
        REG_PLANE_POINT_Y: point_r[1]  <= signed'(cfg_data);
        REG_PLANE_POINT_Z: point_r[2]  <= signed'(cfg_data);
        REG_UNIT_NORMAL_X: normal_r[0] <= signed'(cfg_data[17:0]);
        REG_UNIT_NORMAL_Y: normal_r[1] <= signed'(cfg_data[17:0]);
        REG_UNIT_NORMAL_Z: normal_r[2] <= signed'(cfg_data[17:0]);
        REG_FRICTION:      fric_r      <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lift_prod[i] = 40'(normal_r[i]) * LIFT_Q32 + 40'sd2147483648;
      lift_nxt[i]  = lift_prod[i][39:32];
    end
    fric_clamp = (fric_r > ONE_Q16) ? ONE_Q16 : fric_r;
    scale_nxt  = ONE_Q16 - fric_clamp;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lift_r[i] <= lift_nxt[i];
    end
    scale_r <= scale_nxt;
  end

  // Each stage advances when it is empty or when the stage after it advances.
  always_comb begin
    adv[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = s6_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 0.
  assign in_prev[0] = in_data.prev_x;
  assign in_prev[1] = in_data.prev_y;
  assign in_prev[2] = in_data.prev_z;
  assign in_cur[0]  = in_data.cur_x;
  assign in_cur[1]  = in_data.cur_y;
  assign in_cur[2]  = in_data.cur_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s0_dl_nxt[i] = 33'(point_r[i]) - 33'(in_prev[i]);
      s0_dp_nxt[i] = 33'(point_r[i]) - 33'(in_cur[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        s0_prev_r[i] <= in_prev[i];
        s0_cur_r[i]  <= in_cur[i];
        s0_dl_r[i]   <= s0_dl_nxt[i];
        s0_dp_r[i]   <= s0_dp_nxt[i];
      end
    end
  end

  // Stage 1.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_pl_nxt[i] = 51'(s0_dl_r[i]) * 51'(normal_r[i]);
      s1_pp_nxt[i] = 51'(s0_dp_r[i]) * 51'(normal_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_prev_r[i] <= s0_prev_r[i];
        s1_cur_r[i]  <= s0_cur_r[i];
        s1_pl_r[i]   <= s1_pl_nxt[i];
        s1_pp_r[i]   <= s1_pp_nxt[i];
      end
    end
  end

  // Stage 2.
  assign s2_dl_nxt = 53'(s1_pl_r[0]) + 53'(s1_pl_r[1]) + 53'(s1_pl_r[2]);
  assign s2_dp_nxt = 53'(s1_pp_r[0]) + 53'(s1_pp_r[1]) + 53'(s1_pp_r[2]);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_prev_r[i] <= s1_prev_r[i];
        s2_cur_r[i]  <= s1_cur_r[i];
      end
      s2_dl_r <= s2_dl_nxt;
      s2_dp_r <= s2_dp_nxt;
    end
  end

  // Stage 3. The step crossed when exactly one dot product is positive.
  always_comb begin
    s3_hit_nxt = ((!s2_dl_r[52] && (s2_dl_r != '0)) ^ (!s2_dp_r[52] && (s2_dp_r != '0)));
    dist_sum   = 54'(s2_dp_r) + 54'sd32768;
    plane_dist = dist_sum[53:16];
    for (int i = 0; i < 3; i++) begin
      s3_ap_nxt[i] = 56'(plane_dist) * 56'(normal_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_prev_r[i] <= s2_prev_r[i];
        s3_cur_r[i]  <= s2_cur_r[i];
        s3_ap_r[i]   <= s3_ap_nxt[i];
      end
      s3_hit_r <= s3_hit_nxt;
    end
  end

  // Stage 4.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      along_sum[i]   = 57'(s3_ap_r[i]) + 57'sd32768;
      s4_corr_nxt[i] = 42'(s3_cur_r[i]) + 42'(signed'(along_sum[i][56:16]))
                     - 42'(s3_prev_r[i]) + 42'(lift_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_prev_r[i] <= s3_prev_r[i];
        s4_cur_r[i]  <= s3_cur_r[i];
        s4_corr_r[i] <= s4_corr_nxt[i];
      end
      s4_hit_r <= s3_hit_r;
    end
  end

  // Stage 5.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_m_nxt[i] = 60'(s4_corr_r[i]) * 60'(signed'({1'b0, scale_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        s5_prev_r[i] <= s4_prev_r[i];
        s5_cur_r[i]  <= s4_cur_r[i];
        s5_m_r[i]    <= s5_m_nxt[i];
      end
      s5_hit_r <= s4_hit_r;
    end
  end

  // Stage 6: round, add to the previous position and saturate, then pick that or the current position by hit.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      moved_sum[i] = 61'(s5_m_r[i]) + 61'sd32768;
      pos_sum[i]   = 46'(s5_prev_r[i]) + 46'(signed'(moved_sum[i][60:16]));
      if (pos_sum[i] > 46'sd2147483647) begin
        pos_sat[i] = 32'sh7fffffff;
      end else if (pos_sum[i] < -46'sd2147483648) begin
        pos_sat[i] = 32'sh80000000;
      end else begin
        pos_sat[i] = pos_sum[i][31:0];
      end
    end
    s6_out_nxt.hit = s5_hit_r;
    if (s5_hit_r) begin
      s6_out_nxt.new_x = pos_sat[0];
      s6_out_nxt.new_y = pos_sat[1];
      s6_out_nxt.new_z = pos_sat[2];
    end else begin
      s6_out_nxt.new_x = s5_cur_r[0];
      s6_out_nxt.new_y = s5_cur_r[1];
      s6_out_nxt.new_z = s5_cur_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_out_r <= s6_out_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pcc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pcc_checker
  import pcc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire pcc_out_t out_data
);

  `PCC_ASSERT(a_reset_clears_out, clk, !rst_n |=> !out_valid, "out_valid set after reset")

  `PCC_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  `PCC_ASSERT_RST(a_empty_out_ready, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output stage")

  `PCC_ASSERT_RST(a_drain_ready, clk, rst_n, out_valid && out_ready |-> in_ready, "input stalled during an output transfer")

endmodule

bind plane_collision_correct_top pcc_checker u_pcc_checker (.*);

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
  import pcc_pkg::*;

  localparam int POS_MAX = 32'sh7FFF_FFFF;
  localparam int POS_MIN = 32'sh8000_0000;
  localparam int UNIT = 65536;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;

  class plane_scoreboard;
    longint point[3];
    longint normal[3];
    longint friction;
    pcc_out_t expected_positions[$];
    int mismatches;

    function new();
      point = '{0, 0, 0};
      normal = '{0, longint'(ONE_Q16), 0};
      friction = 0;
      mismatches = 0;
    endfunction

    function void store_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PLANE_POINT_X: point[0] = longint'($signed(value));
        REG_PLANE_POINT_Y: point[1] = longint'($signed(value));
        REG_PLANE_POINT_Z: point[2] = longint'($signed(value));
        REG_UNIT_NORMAL_X: normal[0] = longint'($signed(value[17:0]));
        REG_UNIT_NORMAL_Y: normal[1] = longint'($signed(value[17:0]));
        REG_UNIT_NORMAL_Z: normal[2] = longint'($signed(value[17:0]));
        REG_FRICTION: friction = longint'(value[16:0]);
        default: ;
      endcase
    endfunction

    function longint round_half_up(longint x, int k);
      return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function pcc_out_t corrected_position(pcc_in_t step);
      longint prev[3], cur[3], res[3];
      longint to_prev, to_cur, depth, along, lift, corr, scale;
      pcc_out_t r;
      prev[0] = longint'($signed(step.prev_x));
      prev[1] = longint'($signed(step.prev_y));
      prev[2] = longint'($signed(step.prev_z));
      cur[0] = longint'($signed(step.cur_x));
      cur[1] = longint'($signed(step.cur_y));
      cur[2] = longint'($signed(step.cur_z));
      to_prev = 0;
      to_cur = 0;
      for (int i = 0; i < 3; i++) begin
        to_prev += (point[i] - prev[i]) * normal[i];
        to_cur += (point[i] - cur[i]) * normal[i];
      end
      // The step crossed the plane when exactly one side distance is positive.
      r.hit = ((to_prev > 0) != (to_cur > 0));
      res = cur;
      if (r.hit) begin
        scale = longint'(ONE_Q16) -
                ((friction > longint'(ONE_Q16)) ? longint'(ONE_Q16) : friction);
        depth = round_half_up(to_cur, 16);
        for (int i = 0; i < 3; i++) begin
          along = round_half_up(depth * normal[i], 16);
          lift = round_half_up(normal[i] * longint'(LIFT_Q32), 32);
          corr = cur[i] + along - prev[i] + lift;
          res[i] = prev[i] + round_half_up(corr * scale, 16);
          if (res[i] > POS_MAX) begin
            res[i] = POS_MAX;
          end else if (res[i] < POS_MIN) begin
            res[i] = POS_MIN;
          end
        end
      end
      r.new_x = 32'(res[0]);
      r.new_y = 32'(res[1]);
      r.new_z = 32'(res[2]);
      return r;
    endfunction

    function void note_step(pcc_in_t step);
      expected_positions.push_back(corrected_position(step));
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) begin
        $display("%0t MISMATCH %s", $time, what);
      end
      mismatches++;
    endtask

    task check_position(pcc_out_t got);
      pcc_out_t want;
      string diffs;
      if (expected_positions.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d hit=%0b",
                                  got.new_x, got.new_y, got.new_z, got.hit));
        return;
      end
      want = expected_positions.pop_front();
      diffs = "";
      if (got.new_x !== want.new_x) begin
        diffs = {diffs, $sformatf(" x got %0d want %0d", got.new_x, want.new_x)};
      end
      if (got.new_y !== want.new_y) begin
        diffs = {diffs, $sformatf(" y got %0d want %0d", got.new_y, want.new_y)};
      end
      if (got.new_z !== want.new_z) begin
        diffs = {diffs, $sformatf(" z got %0d want %0d", got.new_z, want.new_z)};
      end
      if (got.hit !== want.hit) begin
        diffs = {diffs, $sformatf(" hit got %0b want %0b", got.hit, want.hit)};
      end
      if (diffs != "") begin
        report_mismatch({"position:", diffs});
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pcc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pcc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  plane_scoreboard sb;

  plane_collision_correct_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_step(in_data);
      if (out_valid && out_ready) sb.check_position(out_data);
      if (cfg_valid && cfg_ready) sb.store_reg(cfg_index, cfg_data);
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_step(input int px, py, pz, cx, cy, cz);
    pcc_in_t item;
    item.prev_x = px;
    item.prev_y = py;
    item.prev_z = pz;
    item.cur_x = cx;
    item.cur_y = cy;
    item.cur_z = cz;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic finish_burst();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_positions.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_plane(input int px, py, pz, nx, ny, nz, fr);
    write_reg(REG_PLANE_POINT_X, px);
    write_reg(REG_PLANE_POINT_Y, py);
    write_reg(REG_PLANE_POINT_Z, pz);
    write_reg(REG_UNIT_NORMAL_X, nx);
    write_reg(REG_UNIT_NORMAL_Y, ny);
    write_reg(REG_UNIT_NORMAL_Z, nz);
    write_reg(REG_FRICTION, fr);
    write_reg(REG_NONE, $urandom);
  endtask

  function automatic int extreme_or_plane(input int base);
    case ($urandom_range(4))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return 0;
      3: return -1;
      default: return base;
    endcase
  endfunction

  task automatic random_steps(input int count);
    int pv[3], cv[3];
    int base, pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        base = int'(sb.point[i]);
        if (pick < 2) begin
          pv[i] = $urandom;
          cv[i] = $urandom;
        end else if (pick < 9) begin
          pv[i] = base + (int'($urandom) >>> $urandom_range(30, 4));
          cv[i] = base + (int'($urandom) >>> $urandom_range(30, 4));
        end else begin
          pv[i] = extreme_or_plane(base);
          cv[i] = extreme_or_plane(base);
        end
      end
      send_step(pv[0], pv[1], pv[2], cv[0], cv[1], cv[2]);
    end
  endtask

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Plane through the origin with an upward normal, as after reset.
    send_step(3 * UNIT, UNIT, -2 * UNIT, 3 * UNIT + 100, -UNIT, -2 * UNIT - 7);
    send_step(0, -UNIT / 2, 0, 5, UNIT / 4, -5);
    send_step(10, UNIT, 10, 20, 2 * UNIT, 20);
    send_step(0, -UNIT, 0, UNIT, 0, -UNIT);
    send_step(0, UNIT, 0, UNIT, 0, -UNIT);
    send_step(7, 0, 7, 7, -3 * UNIT, 7);
    send_step(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
    send_step(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
    send_step(0, 0, 0, 0, 0, 0);
    send_step(-1, -1, -1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    finish_burst();

    // Corrections that run past the position range in both directions.
    load_plane(POS_MAX, POS_MAX, POS_MAX, 0, UNIT, 0, 0);
    send_step(0, POS_MAX, 0, 5, POS_MIN, 5);
    finish_burst();
    load_plane(POS_MIN, POS_MIN, POS_MIN, 0, -UNIT, 0, 0);
    send_step(0, POS_MIN, 0, 0, POS_MAX, 0);
    finish_burst();

    // Full friction, friction beyond full, and half friction.
    load_plane(0, 0, 0, 0, UNIT, 0, UNIT);
    send_step(UNIT, UNIT, UNIT, 2 * UNIT, -UNIT, 3 * UNIT);
    finish_burst();
    load_plane(0, 0, 0, 0, UNIT, 0, 131071);
    send_step(UNIT, UNIT, UNIT, 2 * UNIT, -UNIT, 3 * UNIT);
    finish_burst();
    load_plane(0, 0, UNIT, 0, 0, -UNIT, 32768);
    send_step(UNIT, -UNIT, 3 * UNIT, -UNIT, 2 * UNIT, -4 * UNIT);
    finish_burst();

    // A zero normal never reports a crossing.
    load_plane(UNIT, UNIT, UNIT, 0, 0, 0, 0);
    send_step(0, 0, 0, 2 * UNIT, 2 * UNIT, 2 * UNIT);
    send_step(POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX);
    finish_burst();

    // A normal far from unit length is used as it stands.
    load_plane(0, 0, 0, 131071, -131072, 131071, 0);
    send_step(UNIT, UNIT, UNIT, -UNIT, -2 * UNIT, -UNIT);
    send_step(POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN);
    finish_burst();

    load_plane(3 * UNIT, -5 * UNIT, UNIT, 0, 0, UNIT, 0);
    random_steps(200);
    finish_burst();

    send_idle_pct = 78;
    load_plane(-100 * UNIT, 2 * UNIT, 0, -UNIT, 0, 0, 13107);
    random_steps(200);
    finish_burst();

    send_idle_pct = 0;
    recv_stall_pct = 78;
    load_plane($urandom, $urandom, $urandom, 37837, 37837, 37837, 6554);
    random_steps(200);
    finish_burst();

    send_idle_pct = 22;
    recv_stall_pct = 22;
    load_plane(POS_MAX, POS_MIN, 0, -46341, 0, 46341, UNIT);
    random_steps(200);
    finish_burst();

    // The output is held off long enough for the pipeline to fill and stall its input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_plane(UNIT / 2, 0, -UNIT, 0, -UNIT, 0, 40000);
    hold_left = 300;
    random_steps(150);
    finish_burst();

    send_idle_pct = 22;
    recv_stall_pct = 22;
    load_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_steps(150);
    finish_burst();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_positions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/pcc_pkg.sv
hw/rtl/plane_collision_correct_top.sv
hw/rtl/pcc_checker.sv
verif/tb.sv
